/* rtl/mde_pkg.sv */
package mde_pkg;
   localparam int MAX_CAT    = 16;
   localparam int COUNT_BITS = 20;
   localparam int CAT_W      = $clog2(MAX_CAT);
   localparam int CELLS      = MAX_CAT * MAX_CAT;
   localparam int CELL_W     = $clog2(CELLS);
   localparam int PROD_W     = 2 * COUNT_BITS;
   localparam int QUO_W      = 33;               // Q32 value up to 1.0
   localparam int MUL_W      = (COUNT_BITS > QUO_W) ? COUNT_BITS : QUO_W;
   localparam int ALLELE_W   = 4;
   localparam int DPRIME_W   = 17;
   localparam int SAMPLE_W   = 20;
   localparam int TERM_SHIFT = 48;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [DPRIME_W-1:0]   ONE_Q16 = DPRIME_W'(65536);

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [PROD_W-1:0]     prod_type;
   typedef logic [QUO_W-1:0]      quo_type;
endpackage

/* rtl/mde_if.sv */
interface mde_req_if import mde_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ALLELE_W-1:0] allele_a;
   logic [ALLELE_W-1:0] allele_b;
   logic                last;
   modport source (output valid, allele_a, allele_b, last, input ready);
   modport sink (input valid, allele_a, allele_b, last, output ready);
endinterface

interface mde_rsp_if import mde_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DPRIME_W-1:0] dprime_q16;
   logic [SAMPLE_W-1:0] sample_count;
   modport source (output valid, dprime_q16, sample_count, input ready);
   modport sink (input valid, dprime_q16, sample_count, output ready);
endinterface

/* rtl/mde_ram.sv */
module mde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

/* rtl/mde_div.sv */
// Restoring divider: quotient of num * 2^32 / den, one bit per cycle.
// Expects num <= den.
module mde_div import mde_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  prod_type num,
   input  prod_type den,
   output logic     done,
   output quo_type  quo
);
   localparam int STEP_W = $clog2(QUO_W + 1);

   logic [PROD_W:0]   rem_ff, rem_in, rem_sh;
   prod_type          den_ff, den_in;
   quo_type           quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic              ge;

   always_comb begin
      rem_sh  = (step_ff == '0) ? rem_ff : {rem_ff[PROD_W-1:0], 1'b0};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = den;
         quo_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_in  = {quo_ff[QUO_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

/* rtl/multiallelic_dprime_engine.sv */
// Multiallelic D' engine. Each req word is one sample (a category at each
// of two loci); categories past the top are clamped to the top category.
// A counted sample is a table read, then an increment write to the
// pair-count RAM; once the sample count is full, samples are dropped. The
// word marked last starts the table walk: N*N first, then a scan of each of
// the MAX_CAT^2 pairs; a pair whose two marginals are nonzero takes five
// products on the one shared multiplier and, if its D and bound are nonzero,
// two divides on the shared divider and a final product. Then the rsp word
// is loaded and all counts clear in the same cycle (pair table via
// per-entry valid bits). req is held off from the last word until the rsp
// word is taken.
module multiallelic_dprime_engine import mde_pkg::*; (
   input logic      clock,
   input logic      reset,
   mde_req_if.sink  req_ch,
   mde_rsp_if.source rsp_ch
);
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_INC   = 5'd1;
   localparam logic [4:0] ST_NN    = 5'd2;
   localparam logic [4:0] ST_SCAN  = 5'd3;
   localparam logic [4:0] ST_RD    = 5'd4;
   localparam logic [4:0] ST_M_OBS = 5'd5;
   localparam logic [4:0] ST_M_EXP = 5'd6;
   localparam logic [4:0] ST_M_A   = 5'd7;
   localparam logic [4:0] ST_M_B   = 5'd8;
   localparam logic [4:0] ST_M_C   = 5'd9;
   localparam logic [4:0] ST_SEL   = 5'd10;
   localparam logic [4:0] ST_DQ    = 5'd11;
   localparam logic [4:0] ST_WQ    = 5'd12;
   localparam logic [4:0] ST_TERM  = 5'd13;
   localparam logic [4:0] ST_NEXT  = 5'd14;
   localparam logic [4:0] ST_OUT   = 5'd15;
   localparam logic [4:0] ST_RSP   = 5'd16;
   localparam logic [CAT_W-1:0] CAT_TOP = CAT_W'(MAX_CAT - 1);

   logic [4:0]          state_ff, state_in;
   count_type           fm_ff [MAX_CAT];
   count_type           sm_ff [MAX_CAT];
   count_type           fm_in [MAX_CAT];
   count_type           sm_in [MAX_CAT];
   logic [CELLS-1:0]    vld_ff, vld_in;
   count_type           total_ff, total_in;
   logic                last_ff, last_in;
   logic [CAT_W-1:0]    i_ff, i_in, j_ff, j_in;
   logic [CELL_W-1:0]   cell_ff, cell_in;
   count_type           nab_ff, nab_in, na_ff, na_in, nb_ff, nb_in;
   prod_type            nn_ff, nn_in, obs_ff, obs_in, exp_ff, exp_in;
   prod_type            ma_ff, ma_in, mb_ff, mb_in, mc_ff, mc_in;
   quo_type             dq_ff, dq_in;
   logic [DPRIME_W-1:0] sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DPRIME_W-1:0] rsp_q_ff, rsp_q_in;
   logic [SAMPLE_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic [CAT_W-1:0]    cat_a, cat_b;
   logic [CELL_W-1:0]   cell_sel;
   logic                counted;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [2*MUL_W-1:0]  mul_p;
   logic                ram_we;
   count_type           ram_wd, ram_rd;
   logic                div_start, div_done;
   prod_type            div_num, div_den, dabs, dmax;
   quo_type             div_quo;
   logic [DPRIME_W+1:0] sum_wide;

   // clamp out-of-range categories
   always_comb begin
      cat_a = (32'(req_ch.allele_a) >= MAX_CAT) ? CAT_TOP : CAT_W'(req_ch.allele_a);
      cat_b = (32'(req_ch.allele_b) >= MAX_CAT) ? CAT_TOP : CAT_W'(req_ch.allele_b);
   end

   assign counted  = total_ff < CNT_MAX;
   assign cell_sel = (state_ff == ST_IDLE) ?
                     CELL_W'(32'(cat_a) * MAX_CAT + 32'(cat_b)) :
                     CELL_W'(32'(i_ff) * MAX_CAT + 32'(j_ff));

   mde_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_pair_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cell_ff),
      .wr_data (ram_wd),
      .rd_addr (cell_sel),
      .rd_data (ram_rd)
   );

   mde_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = MUL_W'(total_ff);
      mul_b = MUL_W'(total_ff);
      case (state_ff)
         ST_M_OBS: begin
            mul_a = MUL_W'(nab_ff);
         end
         ST_M_EXP: begin
            mul_a = MUL_W'(na_ff);
            mul_b = MUL_W'(nb_ff);
         end
         ST_M_A: begin
            mul_a = MUL_W'(total_ff - na_ff);
            mul_b = MUL_W'(total_ff - nb_ff);
         end
         ST_M_B: begin
            mul_a = MUL_W'(na_ff);
            mul_b = MUL_W'(total_ff - nb_ff);
         end
         ST_M_C: begin
            mul_a = MUL_W'(nb_ff);
            mul_b = MUL_W'(total_ff - na_ff);
         end
         ST_TERM: begin
            mul_a = MUL_W'(div_quo);
            mul_b = MUL_W'(dq_ff);
         end
         default: begin
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // |D| and Dmax, both scaled by N^2
   always_comb begin
      if (obs_ff < exp_ff) begin
         dabs = exp_ff - obs_ff;
         dmax = (exp_ff < ma_ff) ? exp_ff : ma_ff;
      end else begin
         dabs = obs_ff - exp_ff;
         dmax = (mb_ff < mc_ff) ? mb_ff : mc_ff;
      end
   end

   assign sum_wide = {2'b00, sum_ff} + (DPRIME_W + 2)'(mul_p[2*MUL_W-1:TERM_SHIFT]);

   always_comb begin
      state_in     = state_ff;
      fm_in        = fm_ff;
      sm_in        = sm_ff;
      vld_in       = vld_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cell_in      = cell_ff;
      nab_in       = nab_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      nn_in        = nn_ff;
      obs_in       = obs_ff;
      exp_in       = exp_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      mc_in        = mc_ff;
      dq_in        = dq_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_q_in     = rsp_q_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      ram_we       = 1'b0;
      ram_wd       = vld_ff[cell_ff] ? ram_rd + 1'b1 : count_type'(1);
      div_start    = 1'b0;
      div_num      = dabs;
      div_den      = dmax;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cell_in = cell_sel;
               last_in = req_ch.last;
               if (counted) begin
                  fm_in[cat_a] = fm_ff[cat_a] + 1'b1;
                  sm_in[cat_b] = sm_ff[cat_b] + 1'b1;
                  total_in     = total_ff + 1'b1;
                  state_in     = ST_INC;
               end else if (req_ch.last) begin
                  state_in = ST_NN;
               end
            end
         end
         ST_INC: begin
            ram_we          = 1'b1;
            vld_in[cell_ff] = 1'b1;
            state_in        = last_ff ? ST_NN : ST_IDLE;
         end
         ST_NN: begin
            nn_in    = mul_p[PROD_W-1:0];
            i_in     = '0;
            j_in     = '0;
            sum_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cell_in = cell_sel;
            na_in   = fm_ff[i_ff];
            nb_in   = sm_ff[j_ff];
            // pairs with an empty marginal contribute nothing
            state_in = (fm_ff[i_ff] == '0 || sm_ff[j_ff] == '0) ? ST_NEXT : ST_RD;
         end
         ST_RD: begin
            nab_in   = vld_ff[cell_ff] ? ram_rd : '0;
            state_in = ST_M_OBS;
         end
         ST_M_OBS: begin
            obs_in   = mul_p[PROD_W-1:0];
            state_in = ST_M_EXP;
         end
         ST_M_EXP: begin
            exp_in   = mul_p[PROD_W-1:0];
            state_in = ST_M_A;
         end
         ST_M_A: begin
            ma_in    = mul_p[PROD_W-1:0];
            state_in = ST_M_B;
         end
         ST_M_B: begin
            mb_in    = mul_p[PROD_W-1:0];
            state_in = ST_M_C;
         end
         ST_M_C: begin
            mc_in    = mul_p[PROD_W-1:0];
            state_in = ST_SEL;
         end
         ST_SEL: begin
            // D of zero, or a zero bound, gives a zero term
            if (obs_ff == exp_ff || dmax == '0) begin
               state_in = ST_NEXT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DQ;
            end
         end
         ST_DQ: begin
            div_num = exp_ff;
            div_den = nn_ff;
            if (div_done) begin
               dq_in     = div_quo;
               div_start = 1'b1;
               state_in  = ST_WQ;
            end
         end
         ST_WQ: begin
            if (div_done) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            // divider holds the weight; term = weight * |D'| >> 48
            sum_in   = (sum_wide > (DPRIME_W + 2)'(ONE_Q16)) ? ONE_Q16 :
                       sum_wide[DPRIME_W-1:0];
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (j_ff == CAT_TOP) begin
               j_in = '0;
               if (i_ff == CAT_TOP) begin
                  state_in = ST_OUT;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_q_in     = sum_ff;
            rsp_cnt_in   = SAMPLE_W'(total_ff);
            for (int k = 0; k < MAX_CAT; k++) begin
               fm_in[k] = '0;
               sm_in[k] = '0;
            end
            vld_in   = '0;
            total_in = '0;
            state_in = ST_RSP;
         end
         ST_RSP: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      cell_ff    <= cell_in;
      nab_ff     <= nab_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      nn_ff      <= nn_in;
      obs_ff     <= obs_in;
      exp_ff     <= exp_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      mc_ff      <= mc_in;
      dq_ff      <= dq_in;
      sum_ff     <= sum_in;
      rsp_q_ff   <= rsp_q_in;
      rsp_cnt_ff <= rsp_cnt_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_CAT; k++) begin
            fm_ff[k] <= '0;
            sm_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         fm_ff        <= fm_in;
         sm_ff        <= sm_in;
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.dprime_q16   = rsp_q_ff;
   assign rsp_ch.sample_count = rsp_cnt_ff;
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import mde_pkg::*;

   typedef struct packed {
      logic [ALLELE_W-1:0] allele_a;
      logic [ALLELE_W-1:0] allele_b;
      logic                last;
   } sample_word_t;

   typedef struct packed {
      logic [DPRIME_W-1:0] dprime_q16;
      logic [SAMPLE_W-1:0] sample_count;
   } dprime_word_t;

   logic clock;
   logic reset;

   mde_req_if req_ch ();
   mde_rsp_if rsp_ch ();

   multiallelic_dprime_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // samples waiting to go out, and D' words the engine still owes us
   sample_word_t sample_queue[$];
   dprime_word_t dprime_expected[$];

   // local copy of the count store
   logic [63:0] pair_tally[CELLS];
   logic [63:0] first_tally[MAX_CAT];
   logic [63:0] second_tally[MAX_CAT];
   logic [63:0] sample_tally;

   int error_count = 0;
   bit req_taken   = 0;
   int req_gap     = 0;
   int rsp_gap     = 0;
   int rsp_hold    = 0;     // long hold-off of the receiver, in cycles
   bit quiet_mode  = 0;     // stretch with no idling at all
   bit hold_done   = 0;
   int sets_seen   = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // all inputs known from time zero
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.allele_a  = '0;
      req_ch.allele_b  = '0;
      req_ch.last      = 1'b0;
      rsp_ch.ready     = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // floor(a*b/c), saturating at 64 bits; zero divisor gives zero
   function automatic logic [63:0] scaled_quotient(input logic [63:0] a,
                                                   input logic [63:0] b,
                                                   input logic [63:0] c);
      logic [127:0] prod;
      logic [127:0] quo;
      if (c == 0) return 64'd0;
      prod = {64'd0, a} * {64'd0, b};
      quo  = prod / {64'd0, c};
      return (quo[127:64] != 0) ? {64{1'b1}} : quo[63:0];
   endfunction

   // weighted |D'| contribution of one category pair, Q16
   function automatic logic [63:0] ld_term(input logic [63:0] n, input logic [63:0] na,
                                           input logic [63:0] nb, input logic [63:0] nab);
      logic [63:0] obs, indep, dev, dmax, dq, wq;
      obs   = nab * n;
      indep = na * nb;
      if (obs == indep || n == 0) return 64'd0;
      if (obs < indep) begin
         dev  = indep - obs;
         dmax = ((n - na) * (n - nb) < na * nb) ? (n - na) * (n - nb) : na * nb;
      end else begin
         dev  = obs - indep;
         dmax = (nb * (n - na) < na * (n - nb)) ? nb * (n - na) : na * (n - nb);
      end
      if (dmax == 0) return 64'd0;
      dq = scaled_quotient(dev, 64'd1 << 32, dmax);
      wq = scaled_quotient(na * nb, 64'd1 << 32, n * n);
      return scaled_quotient(wq, dq, 64'd1 << 48);
   endfunction

   task automatic clear_tallies();
      for (int i = 0; i < CELLS; i++) pair_tally[i] = 0;
      for (int i = 0; i < MAX_CAT; i++) begin
         first_tally[i]  = 0;
         second_tally[i] = 0;
      end
      sample_tally = 0;
   endtask

   // count one accepted sample; on last, queue the D' word it causes
   task automatic count_sample(input sample_word_t s);
      logic [63:0] sum;
      dprime_word_t w;
      int a, b;
      a = (s.allele_a >= MAX_CAT) ? MAX_CAT - 1 : s.allele_a;
      b = (s.allele_b >= MAX_CAT) ? MAX_CAT - 1 : s.allele_b;
      if (sample_tally < {44'd0, CNT_MAX}) begin
         pair_tally[a * MAX_CAT + b]++;
         first_tally[a]++;
         second_tally[b]++;
         sample_tally++;
      end
      if (s.last) begin
         sum = 0;
         for (int i = 0; i < MAX_CAT; i++) begin
            if (first_tally[i] == 0) continue;
            for (int j = 0; j < MAX_CAT; j++) begin
               if (second_tally[j] == 0) continue;
               sum += ld_term(sample_tally, first_tally[i], second_tally[j],
                              pair_tally[i * MAX_CAT + j]);
               if (sum > 64'd65536) sum = 64'd65536;
            end
         end
         w.dprime_q16   = sum[DPRIME_W-1:0];
         w.sample_count = sample_tally[SAMPLE_W-1:0];
         dprime_expected.push_back(w);
         clear_tallies();
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic push_sample(input int a, input int b, input bit last);
      sample_word_t s;
      s.allele_a = a[ALLELE_W-1:0];
      s.allele_b = b[ALLELE_W-1:0];
      s.last     = last;
      sample_queue.push_back(s);
   endtask

   // one random set; most are small so the walk stays short
   task automatic push_random_set();
      int len, style, a, b;
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      style = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
         a = $urandom_range(0, 15);
         case (style)
            0: b = $urandom_range(0, 15);                    // independent
            1: b = a;                                         // full coupling
            2: b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 15 - a;
            default: begin                                    // few categories
               a = $urandom_range(0, 2) * 7;
               b = ($urandom_range(0, 1) == 0) ? a : $urandom_range(13, 15);
            end
         endcase
         push_sample(a, b, k == len - 1);
      end
   endtask

   // stimulus
   initial begin
      clear_tallies();
      // single sample, lowest and highest categories
      push_sample(0, 0, 1);
      push_sample(15, 15, 1);
      // perfect coupling, two categories each
      push_sample(0, 0, 0); push_sample(15, 15, 0);
      push_sample(0, 0, 0); push_sample(15, 15, 1);
      // perfect repulsion
      push_sample(0, 15, 0); push_sample(15, 0, 0); push_sample(0, 15, 1);
      // independence, zero D everywhere
      push_sample(3, 5, 0); push_sample(3, 9, 0); push_sample(12, 5, 0); push_sample(12, 9, 1);
      // one locus monomorphic
      push_sample(7, 1, 0); push_sample(7, 14, 0); push_sample(7, 10, 1);
      // mixed bit patterns
      push_sample(10, 5, 0); push_sample(5, 10, 0); push_sample(10, 10, 0);
      push_sample(6, 9, 1);
      while (sample_queue.size() < 500) push_random_set();

      @(negedge clock);
      wait (!reset);
      wait (sample_queue.size() == 0 && !req_ch.valid);
      wait (dprime_expected.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // req driver: changes at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_ch.valid && !req_taken) begin
            // word still pending, hold it
         end else if (req_gap > 0 || sample_queue.size() == 0) begin
            req_ch.valid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end else begin
            sample_word_t s;
            s = sample_queue.pop_front();
            req_ch.allele_a <= s.allele_a;
            req_ch.allele_b <= s.allele_b;
            req_ch.last     <= s.last;
            req_ch.valid    <= 1'b1;
            req_gap = pick_gap();
         end
         // now and then a stretch with no idling
         if ($urandom_range(0, 499) == 0) quiet_mode = ~quiet_mode;
      end
      req_taken = 0;
   end

   // rsp ready: random idling plus one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && sets_seen == 5) begin
            rsp_hold  = 3000;
            hold_done = 1;
         end
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
         end else if (rsp_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_gap = pick_gap();
         end
      end
   end

   // sample side: predict on every accepted req word
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sample_word_t s;
         s.allele_a = req_ch.allele_a;
         s.allele_b = req_ch.allele_b;
         s.last     = req_ch.last;
         count_sample(s);
         req_taken = 1;
      end
   end

   // rsp monitor: compare each word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         dprime_word_t w;
         sets_seen++;
         if (dprime_expected.size() == 0) begin
            report_mismatch("unexpected rsp word, dprime", 64'(rsp_ch.dprime_q16), 64'd0);
         end else begin
            w = dprime_expected.pop_front();
            if (rsp_ch.dprime_q16 !== w.dprime_q16)
               report_mismatch("dprime_q16", 64'(rsp_ch.dprime_q16), 64'(w.dprime_q16));
            if (rsp_ch.sample_count !== w.sample_count)
               report_mismatch("sample_count", 64'(rsp_ch.sample_count),
                               64'(w.sample_count));
         end
      end
   end

   // timeout
   initial begin
      #400ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule

/* sim.f */
rtl/mde_pkg.sv
rtl/mde_if.sv
rtl/mde_ram.sv
rtl/mde_div.sv
rtl/multiallelic_dprime_engine.sv
bench/tb.sv
